@@ hdl/tq_pkg.sv @@
// Shared types and helpers of the team queue.
// Operation and status codes, the item that crosses from front to back,
// the back-end sequencer states and a small modulo helper.
`default_nettype none

package tq_pkg;

   typedef enum logic [1:0] {
      FUNC_ASSIGN  = 2'd0,
      FUNC_ENQUEUE = 2'd1,
      FUNC_DEQUEUE = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DEQ      = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ENQ_META,
      BK_DEQ_RING,
      BK_DEQ_META,
      BK_DEQ_STORE
   } bk_state_type;

   localparam int SID_W = 10;
   localparam int CID_W = 4;
   localparam int MOD_STEPS = 6;

   typedef struct packed {
      func_type         op;
      logic [SID_W-1:0] sid;
      logic [CID_W-1:0] cls;
   } item_type;

   // Remainder of a 10-bit value by a modulus of at least 16, or of a 4-bit
   // value by a modulus of at least 2, by restoring subtraction.
   function automatic logic [SID_W-1:0] wrap_mod(input logic [SID_W-1:0] value,
                                                 input logic [14:0] modulus);
      logic [20:0] rem;
      logic [20:0] part;
      rem = {11'd0, value};
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         part = {6'd0, modulus} << k;
         if (rem >= part) begin
            rem = rem - part;
         end
      end
      return rem[SID_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/tq_if.sv @@
// Request and response channel interfaces of the team queue.
// Valid/ready handshake; payload widths are fixed, no package needed.
`default_nettype none

interface tq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [9:0] student_id;
   logic [3:0] class_id;

   modport source (output valid, output func, output student_id, output class_id,
                   input ready);
   modport sink (input valid, input func, input student_id, input class_id,
                 output ready);
endinterface

interface tq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [9:0] dequeued_id;

   modport source (output valid, output status, output dequeued_id, input ready);
   modport sink (input valid, input status, input dequeued_id, output ready);
endinterface

`default_nettype wire

@@ hdl/tq_front.sv @@
// Front end of the team queue: accepts requests, owns the student-to-class
// table, and hands classified items to the queue. Uses tq_pkg and tq_req_if.
`default_nettype none

module tq_front
   import tq_pkg::*;
#(
   parameter int NUM_CLASSES  = 16,
   parameter int NUM_STUDENTS = 1024
) (
   input  wire         clock,
   input  wire         reset,
   tq_req_if.sink      req_if,
   output logic        push_valid,
   input  wire         push_ready,
   output item_type    push_item
);

   localparam int SW = $clog2(NUM_STUDENTS);

   logic [CID_W-1:0] cls_mem [NUM_STUDENTS];

   logic             clr_busy_ff, clr_busy_in;
   logic [SW-1:0]    clr_addr_ff, clr_addr_in;
   logic             stg_valid_ff, stg_valid_in;
   func_type         stg_op_ff;
   logic [SID_W-1:0] stg_sid_ff;
   logic [CID_W-1:0] tbl_rd_ff;

   logic             accept;
   logic [SID_W-1:0] sid_wrap;
   logic [SID_W-1:0] cid_full;
   logic [CID_W-1:0] cid_wrap;
   logic [SW-1:0]    tbl_addr;

   assign req_if.ready = !clr_busy_ff && (!stg_valid_ff || push_ready);
   assign accept       = req_if.valid && req_if.ready;

   assign sid_wrap = wrap_mod(req_if.student_id, 15'(NUM_STUDENTS));
   assign cid_full = wrap_mod({6'd0, req_if.class_id}, 15'(NUM_CLASSES));
   assign cid_wrap = cid_full[CID_W-1:0];
   assign tbl_addr = SW'(sid_wrap);

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == SW'(NUM_STUDENTS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (push_ready) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_op_ff  <= func_type'(req_if.func);
         stg_sid_ff <= sid_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         cls_mem[clr_addr_ff] <= '0;
      end else if (accept && func_type'(req_if.func) == FUNC_ASSIGN) begin
         cls_mem[tbl_addr] <= cid_wrap;
      end
      if (accept) begin
         tbl_rd_ff <= cls_mem[tbl_addr];
      end
   end

   assign push_valid    = stg_valid_ff;
   assign push_item.op  = stg_op_ff;
   assign push_item.sid = stg_sid_ff;
   assign push_item.cls = tbl_rd_ff;

endmodule

`default_nettype wire

@@ hdl/tq_queue.sv @@
// Two-entry item queue between the front and back ends of the team queue.
// Depends on item_type from tq_pkg.
`default_nettype none

module tq_queue
   import tq_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   input  wire       push_valid,
   output logic      push_ready,
   input  item_type  push_item,
   output logic      pop_valid,
   input  wire       pop_ready,
   output item_type  pop_item
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   item_type         q_mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != (PTR_W + 1)'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ hdl/tq_back.sv @@
// Back end of the team queue: class FIFOs, class-order ring and response
// register, run by a small sequencer. Uses tq_pkg and tq_rsp_if.
`default_nettype none

module tq_back
   import tq_pkg::*;
#(
   parameter int NUM_CLASSES      = 16,
   parameter int CLASS_FIFO_DEPTH = 256
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        pop_valid,
   output logic       pop_ready,
   input  item_type   pop_item,
   tq_rsp_if.source   rsp_if
);

   localparam int CW = $clog2(NUM_CLASSES);
   localparam int PW = $clog2(CLASS_FIFO_DEPTH);

   typedef struct packed {
      logic [PW-1:0] head;
      logic [PW-1:0] tail;
      logic [PW:0]   count;
   } meta_type;

   meta_type         meta_mem  [NUM_CLASSES];
   logic [CW-1:0]    ring_mem  [NUM_CLASSES];
   logic [SID_W-1:0] store_mem [2**(CW+PW)];

   bk_state_type     state_ff, state_in;
   logic [SID_W-1:0] cur_sid_ff, cur_sid_in;
   logic [CW-1:0]    cur_cls_ff, cur_cls_in;
   logic [CW-1:0]    order_head_ff, order_head_in;
   logic [CW-1:0]    order_tail_ff, order_tail_in;
   logic [CW:0]      order_cnt_ff, order_cnt_in;
   logic [NUM_CLASSES-1:0] meta_valid_ff;

   meta_type         meta_rd_ff;
   logic             meta_rd_vld_ff;
   logic [CW-1:0]    ring_rd_ff;
   logic [SID_W-1:0] store_rd_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [SID_W-1:0] rsp_id_ff, rsp_id_in;

   logic             out_free;
   meta_type         meta_cur;
   meta_type         meta_wdata;
   logic             meta_we;
   logic [CW-1:0]    meta_raddr;
   logic             ring_we;
   logic             store_we;
   logic [CW+PW-1:0] store_waddr;
   logic [CW+PW-1:0] store_raddr;
   logic [PW-1:0]    next_tail;
   logic [PW-1:0]    next_head;
   logic [CW-1:0]    next_order_tail;
   logic [CW-1:0]    next_order_head;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign pop_ready = (state_ff == BK_IDLE) && out_free;
   assign meta_cur  = meta_rd_vld_ff ? meta_rd_ff : '0;

   assign next_tail = (meta_cur.tail == PW'(CLASS_FIFO_DEPTH - 1)) ? '0 : meta_cur.tail + 1'b1;
   assign next_head = (meta_cur.head == PW'(CLASS_FIFO_DEPTH - 1)) ? '0 : meta_cur.head + 1'b1;
   assign next_order_tail = (order_tail_ff == CW'(NUM_CLASSES - 1)) ? '0 :
                            order_tail_ff + 1'b1;
   assign next_order_head = (order_head_ff == CW'(NUM_CLASSES - 1)) ? '0 :
                            order_head_ff + 1'b1;
   assign store_waddr = {cur_cls_ff, meta_cur.tail};
   assign store_raddr = {cur_cls_ff, meta_cur.head};

   always_comb begin
      state_in      = state_ff;
      cur_sid_in    = cur_sid_ff;
      cur_cls_in    = cur_cls_ff;
      order_head_in = order_head_ff;
      order_tail_in = order_tail_ff;
      order_cnt_in  = order_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      meta_raddr    = CW'(pop_item.cls);
      meta_we       = 1'b0;
      meta_wdata    = meta_cur;
      ring_we       = 1'b0;
      store_we      = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (pop_valid && out_free) begin
               cur_sid_in = pop_item.sid;
               cur_cls_in = CW'(pop_item.cls);
               unique case (pop_item.op) inside
                  FUNC_ASSIGN, FUNC_NONE: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_id_in     = '0;
                  end
                  FUNC_ENQUEUE: begin
                     state_in = BK_ENQ_META;
                  end
                  FUNC_DEQUEUE: begin
                     if (order_cnt_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_id_in     = '0;
                     end else begin
                        state_in = BK_DEQ_RING;
                     end
                  end
               endcase
            end
         end
         BK_ENQ_META: begin
            rsp_valid_in = 1'b1;
            rsp_id_in    = '0;
            state_in     = BK_IDLE;
            if (meta_cur.count >= (PW + 1)'(CLASS_FIFO_DEPTH)) begin
               rsp_status_in = STATUS_OVERFLOW;
            end else begin
               rsp_status_in    = STATUS_OK;
               store_we         = 1'b1;
               meta_we          = 1'b1;
               meta_wdata.tail  = next_tail;
               meta_wdata.count = meta_cur.count + 1'b1;
               if (meta_cur.count == '0) begin
                  ring_we       = 1'b1;
                  order_tail_in = next_order_tail;
                  order_cnt_in  = order_cnt_ff + 1'b1;
               end
            end
         end
         BK_DEQ_RING: begin
            cur_cls_in = ring_rd_ff;
            meta_raddr = ring_rd_ff;
            state_in   = BK_DEQ_META;
         end
         BK_DEQ_META: begin
            if (meta_cur.count == '0) begin
               order_head_in = next_order_head;
               order_cnt_in  = order_cnt_ff - 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_EMPTY;
               rsp_id_in     = '0;
               state_in      = BK_IDLE;
            end else begin
               meta_we          = 1'b1;
               meta_wdata.head  = next_head;
               meta_wdata.count = meta_cur.count - 1'b1;
               if (meta_cur.count == (PW + 1)'(1)) begin
                  order_head_in = next_order_head;
                  order_cnt_in  = order_cnt_ff - 1'b1;
               end
               state_in = BK_DEQ_STORE;
            end
         end
         BK_DEQ_STORE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_DEQ;
            rsp_id_in     = store_rd_ff;
            state_in      = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         order_head_ff <= '0;
         order_tail_ff <= '0;
         order_cnt_ff  <= '0;
         meta_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         order_head_ff <= order_head_in;
         order_tail_ff <= order_tail_in;
         order_cnt_ff  <= order_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (meta_we) begin
            meta_valid_ff[cur_cls_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_sid_ff     <= cur_sid_in;
      cur_cls_ff     <= cur_cls_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      meta_rd_vld_ff <= meta_valid_ff[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[cur_cls_ff] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[order_tail_ff] <= cur_cls_ff;
      end
      ring_rd_ff <= ring_mem[order_head_ff];
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= cur_sid_ff;
      end
      store_rd_ff <= store_mem[store_raddr];
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.dequeued_id = rsp_id_ff;

endmodule

`default_nettype wire

@@ hdl/team_queue.sv @@
// Top level of the team queue: front end, item queue and back end.
// Depends on tq_pkg, tq_if, tq_front, tq_queue and tq_back.
//
//   Channel   Direction  Handshake          Payload
//   req_if    in         valid/ready        func, student_id, class_id
//   rsp_if    out        valid/ready        status, dequeued_id
//
// The front end takes one request per cycle while the two-entry queue has room.
// The back end handles one request at a time. Assign and unused codes, and a
// dequeue on an empty queue, are answered from the idle state; an enqueue updates
// the class record; a dequeue reads order ring, class record, then member store.
// After reset the class table is cleared, one entry per cycle, across all
// NUM_STUDENTS entries; no request is taken until that pass ends.
// A stalled response holds the back end, but the front end keeps filling the queue.
`default_nettype none

module team_queue
   import tq_pkg::*;
#(
   parameter int NUM_CLASSES      = 16,
   parameter int NUM_STUDENTS     = 1024,
   parameter int CLASS_FIFO_DEPTH = 256
) (
   input  wire       clock,
   input  wire       reset,
   tq_req_if.sink    req_if,
   tq_rsp_if.source  rsp_if
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   tq_front #(
      .NUM_CLASSES  (NUM_CLASSES),
      .NUM_STUDENTS (NUM_STUDENTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   tq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tq_back #(
      .NUM_CLASSES      (NUM_CLASSES),
      .CLASS_FIFO_DEPTH (CLASS_FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
